/* design/hss_pkg.sv */
// Shared types and constants for the Horspool substring search block.
// Used by the front, queue, back and top-level modules; depends on nothing.
package hss_pkg;

    localparam int PATTERN_MAX_DEF = 64;
    localparam int TEXT_MAX_DEF    = 4096;
    localparam int POS_W           = 12;

    localparam logic OP_PATTERN = 1'b0;
    localparam logic OP_TEXT    = 1'b1;

    // One classified input item as it travels from the front to the back.
    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
        logic       last;
        logic       new_pattern;
        logic       need_build;
        logic       new_text;
    } t_item;

endpackage

/* design/hss_front.sv */
// Front end of the substring search: accepts input transactions and classifies them.
// Depends on hss_pkg for the item type and op codes.
module hss_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_op,
    input  logic [7:0]    i_data_byte,
    input  logic          i_last,
    output logic          o_stall,
    output logic          o_push,
    output hss_pkg::t_item o_item,
    input  logic          i_full
);
    import hss_pkg::*;

    logic r_pattern_closed;
    logic r_text_closed;

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_item.op          = i_op;
        o_item.data_byte   = i_data_byte;
        o_item.last        = i_last;
        o_item.new_pattern = (i_op == OP_PATTERN) && r_pattern_closed;
        o_item.need_build  = (i_op == OP_TEXT) && !r_pattern_closed;
        o_item.new_text    = (i_op == OP_TEXT) && r_text_closed;
    end

    // Track string boundaries so the back end is told where each string starts.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_closed <= 1'b1;
            r_text_closed    <= 1'b1;
        end else if (o_push) begin
            if (i_op == OP_PATTERN) begin
                r_pattern_closed <= i_last;
                if (r_pattern_closed) begin
                    r_text_closed <= 1'b1;
                end
            end else begin
                r_pattern_closed <= 1'b1;
                r_text_closed    <= i_last;
            end
        end
    end

endmodule

/* design/hss_queue.sv */
// Short FIFO of classified items between the front and the back end.
// Depends on hss_pkg for the item type.
module hss_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  hss_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output hss_pkg::t_item o_item
);
    import hss_pkg::*;

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    t_item         r_slot [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [AW:0]   r_count;
    logic          do_pop;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_slot[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + (AW+1)'(1);
            end else if (!i_push && do_pop) begin
                r_count <= r_count - (AW+1)'(1);
            end
        end
    end

endmodule

/* design/hss_back.sv */
// Back end of the substring search: string stores, shift table build and the search.
// Depends on hss_pkg for the item type, op codes and result width.
module hss_back #(
    parameter int PATTERN_MAX = hss_pkg::PATTERN_MAX_DEF,
    parameter int TEXT_MAX    = hss_pkg::TEXT_MAX_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_q_valid,
    input  hss_pkg::t_item            i_q_item,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic                      o_found,
    output logic [hss_pkg::POS_W-1:0] o_position,
    output logic                      o_overflow
);
    import hss_pkg::*;

    localparam int LW  = $clog2(PATTERN_MAX + 1);
    localparam int TW  = $clog2(TEXT_MAX + 1);
    localparam int NW  = $clog2(TEXT_MAX + PATTERN_MAX + 1);
    localparam int PAW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int TAW = $clog2(TEXT_MAX);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_BLD  = 3'd1;
    localparam logic [2:0] S_TXT  = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_CMP  = 3'd4;
    localparam logic [2:0] S_SHF  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [7:0]    r_pmem [PATTERN_MAX];
    logic [7:0]    r_tmem [TEXT_MAX];
    logic [LW-1:0] r_tab  [256];
    logic [255:0]  r_svalid;

    logic [2:0]    r_state;
    logic [LW-1:0] r_plen;
    logic [TW-1:0] r_tlen;
    logic          r_pov;
    logic          r_ovf;
    logic [LW-1:0] r_m;
    logic          r_rd_pend;
    logic [LW-1:0] r_rd_shift;
    logic [7:0]    r_hold_byte;
    logic          r_hold_last;
    logic          r_hold_new;
    logic          r_hold_txt;
    logic [NW-1:0] r_n;
    logic [LW-1:0] r_k;
    logic [7:0]    r_c;
    logic          r_res_found;
    logic [NW-1:0] r_res_pos;
    logic          r_out_valid;
    logic          r_out_found;
    logic [POS_W-1:0] r_out_pos;
    logic          r_out_ovf;
    logic [7:0]    r_p_q;
    logic [7:0]    r_t_q;
    logic [LW-1:0] r_tab_q;

    logic          pat_go;
    logic          tx_go;
    logic [7:0]    tx_byte;
    logic          tx_last;
    logic          tx_new;
    logic [TW-1:0] tx_base;
    logic          tx_full;
    logic [TW-1:0] tx_len;
    logic          tx_ovf;
    logic [LW-1:0] pat_base;
    logic          bld_issue;
    logic [LW-1:0] srch_paddr;
    logic [NW-1:0] srch_taddr;
    logic [PAW-1:0] p_raddr;
    logic [7:0]    tab_raddr;
    logic [NW-1:0] n_shift;
    logic [NW-1:0] n_next;

    assign o_pop = (r_state == S_IDLE) && i_q_valid;
    assign pat_go = o_pop && (i_q_item.op == OP_PATTERN);
    assign tx_go  = (o_pop && (i_q_item.op == OP_TEXT) && !i_q_item.need_build)
                    || (r_state == S_TXT);
    assign tx_byte = (r_state == S_TXT) ? r_hold_byte : i_q_item.data_byte;
    assign tx_last = (r_state == S_TXT) ? r_hold_last : i_q_item.last;
    assign tx_new  = (r_state == S_TXT) ? r_hold_new  : i_q_item.new_text;
    assign tx_base = tx_new ? '0 : r_tlen;
    assign tx_full = (tx_base >= TW'(TEXT_MAX));
    assign tx_len  = tx_full ? tx_base : tx_base + TW'(1);
    assign tx_ovf  = (tx_new ? r_pov : r_ovf) | tx_full;
    assign pat_base = i_q_item.new_pattern ? '0 : r_plen;

    assign bld_issue  = (r_state == S_BLD)
                        && (({1'b0, r_m} + (LW+1)'(1)) < {1'b0, r_plen});
    assign srch_paddr = r_plen - LW'(1) - r_k;
    assign srch_taddr = r_n - NW'(r_k);
    assign p_raddr    = (r_state == S_BLD) ? PAW'(r_m) : PAW'(srch_paddr);
    assign tab_raddr  = (r_k == '0) ? r_t_q : r_c;
    assign n_shift    = r_svalid[r_c] ? NW'(r_tab_q) : NW'(r_plen);
    assign n_next     = r_n + n_shift;

    assign o_valid    = r_out_valid;
    assign o_found    = r_out_found;
    assign o_position = r_out_pos;
    assign o_overflow = r_out_ovf;

    // Pattern store: written on loads, read by the table build and the search.
    always_ff @(posedge i_clk) begin
        if (pat_go && (pat_base < LW'(PATTERN_MAX))) begin
            r_pmem[PAW'(pat_base)] <= i_q_item.data_byte;
        end
        r_p_q <= r_pmem[p_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (tx_go && !tx_full) begin
            r_tmem[TAW'(tx_base)] <= tx_byte;
        end
        r_t_q <= r_tmem[TAW'(srch_taddr)];
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_BLD) && r_rd_pend) begin
            r_tab[r_p_q] <= r_rd_shift;
        end
        r_tab_q <= r_tab[tab_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_plen      <= '0;
            r_tlen      <= '0;
            r_pov       <= 1'b0;
            r_ovf       <= 1'b0;
            r_svalid    <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (pat_go) begin
                        if (i_q_item.new_pattern) begin
                            r_tlen <= '0;
                            r_pov  <= 1'b0;
                            r_ovf  <= 1'b0;
                        end
                        if (pat_base < LW'(PATTERN_MAX)) begin
                            r_plen <= pat_base + LW'(1);
                        end else begin
                            r_plen <= pat_base;
                            r_pov  <= 1'b1;
                            r_ovf  <= 1'b1;
                        end
                        if (i_q_item.last) begin
                            r_state    <= S_BLD;
                            r_hold_txt <= 1'b0;
                            r_m        <= '0;
                            r_svalid   <= '0;
                        end
                    end else if (o_pop && i_q_item.need_build) begin
                        r_state     <= S_BLD;
                        r_hold_byte <= i_q_item.data_byte;
                        r_hold_last <= i_q_item.last;
                        r_hold_new  <= i_q_item.new_text;
                        r_hold_txt  <= 1'b1;
                        r_m         <= '0;
                        r_svalid    <= '0;
                    end
                end
                S_BLD: begin
                    r_rd_pend <= bld_issue;
                    if (bld_issue) begin
                        r_rd_shift <= r_plen - LW'(1) - r_m;
                        r_m        <= r_m + LW'(1);
                    end
                    if (r_rd_pend) begin
                        r_svalid[r_p_q] <= 1'b1;
                    end
                    if (!bld_issue && !r_rd_pend) begin
                        // The held flag marks a text byte that waited for this build.
                        r_state <= r_hold_txt ? S_TXT : S_IDLE;
                    end
                end
                S_RD: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (r_k == '0) begin
                        r_c <= r_t_q;
                    end
                    if (r_p_q == r_t_q) begin
                        if ((r_k + LW'(1)) == r_plen) begin
                            r_res_found <= 1'b1;
                            r_res_pos   <= r_n + NW'(1) - NW'(r_plen);
                            r_state     <= S_OUT;
                        end else begin
                            r_k     <= r_k + LW'(1);
                            r_state <= S_RD;
                        end
                    end else begin
                        r_state <= S_SHF;
                    end
                end
                S_SHF: begin
                    r_k <= '0;
                    if (n_next >= NW'(r_tlen)) begin
                        r_res_found <= 1'b0;
                        r_res_pos   <= '0;
                        r_state     <= S_OUT;
                    end else begin
                        r_n     <= n_next;
                        r_state <= S_RD;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_found <= r_res_found;
                        r_out_pos   <= POS_W'(r_res_pos);
                        r_out_ovf   <= r_ovf;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            // Text bytes are stored from the idle state or after a pending build.
            if (tx_go) begin
                r_tlen <= tx_len;
                r_ovf  <= tx_ovf;
                if (r_state == S_TXT) begin
                    r_state <= S_IDLE;
                end
                if (tx_last) begin
                    r_k <= '0;
                    r_n <= NW'(r_plen) - NW'(1);
                    if (r_plen == '0) begin
                        r_res_found <= 1'b1;
                        r_res_pos   <= '0;
                        r_state     <= S_OUT;
                    end else if (NW'(tx_len) < NW'(r_plen)) begin
                        r_res_found <= 1'b0;
                        r_res_pos   <= '0;
                        r_state     <= S_OUT;
                    end else begin
                        r_state <= S_RD;
                    end
                end
            end
        end
    end

endmodule

/* design/horspool_substring_search.sv */
// Horspool substring search: pattern and text bytes in, one found/position result per text.
// Bytes are loaded into the pattern and text stores; a pattern close adds a shift table
// build, and the search steps through read, compare and shift states, paced by the
// registered reads of the pattern, text and shift table memories.
// Reset (synchronous, active low) empties the queue, zeroes lengths, overflow and table
// valid bits; the byte stores need no clearing and are never read before being written.
module horspool_substring_search #(
    parameter int PATTERN_MAX = hss_pkg::PATTERN_MAX_DEF,
    parameter int TEXT_MAX    = hss_pkg::TEXT_MAX_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_op,
    input  logic [7:0]                i_data_byte,
    input  logic                      i_last,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic                      o_found,
    output logic [hss_pkg::POS_W-1:0] o_position,
    output logic                      o_overflow
);
    import hss_pkg::*;

    // The front classifies each transaction against the string boundaries it has seen,
    // so the back end knows when a new pattern or text begins and when a table build
    // must run before a text byte.
    t_item push_item;
    t_item pop_item;
    logic  push;
    logic  full;
    logic  pop;
    logic  q_valid;

    hss_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_op        (i_op),
        .i_data_byte (i_data_byte),
        .i_last      (i_last),
        .o_stall     (o_stall),
        .o_push      (push),
        .o_item      (push_item),
        .i_full      (full)
    );

    // The queue decouples input acceptance from the long search, so input stalls
    // only once it fills while the back end is busy.
    hss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (pop_item)
    );

    // The back end owns the stores and the search; its result register lets it go on
    // loading the next strings while a finished result waits to be taken.
    hss_back #(
        .PATTERN_MAX (PATTERN_MAX),
        .TEXT_MAX    (TEXT_MAX)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_item   (pop_item),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_found    (o_found),
        .o_position (o_position),
        .o_overflow (o_overflow)
    );

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the Horspool substring search block.
// Depends on hss_pkg and horspool_substring_search; drives patterns and texts, checks results.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hss_pkg::*;

    localparam int PMAX = PATTERN_MAX_DEF;
    localparam int TMAX = TEXT_MAX_DEF;
    localparam int CYCLE_LIMIT = 3000000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic                 i_op;
    logic [7:0]           i_data_byte;
    logic                 i_last;
    logic                 o_valid;
    logic                 i_stall;
    logic                 o_found;
    logic [POS_W-1:0]     o_position;
    logic                 o_overflow;

    horspool_substring_search u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_op        (i_op),
        .i_data_byte (i_data_byte),
        .i_last      (i_last),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_found     (o_found),
        .o_position  (o_position),
        .o_overflow  (o_overflow)
    );

    // One search result as the block reports it.
    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
        logic             overflow;
    } t_match;

    // One input transaction of the directed table, with an optional typed-in result.
    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
        logic       last;
        logic       has_typed;
        t_match     typed;
    } t_row;

    // Predictor state: our own mirror of the search engine.
    logic [7:0] pat_mem [PMAX];
    int         pat_len;
    logic [6:0] skip_dist [256];
    logic       skip_ok [256];
    logic [7:0] txt_mem [TMAX];
    int         txt_len;
    logic       ovf_any;
    logic       pat_done;
    logic       txt_done;
    logic       pat_ovf;

    t_match     pending_matches [$];
    int         errors;
    int         results_seen;
    int         found_seen;
    int         ovf_seen;
    int         cycles;
    logic       quiet_mode;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Build the bad-character table; the last occurrence in the pattern wins.
    function automatic void close_pattern();
        for (int c = 0; c < 256; c++) skip_ok[c] = 1'b0;
        for (int m = 0; m + 1 < pat_len; m++) begin
            skip_dist[pat_mem[m]] = 7'(pat_len - 1 - m);
            skip_ok[pat_mem[m]]   = 1'b1;
        end
        pat_done = 1'b1;
    endfunction

    // Horspool scan: right-to-left compare, then skip by the window's last text byte.
    function automatic t_match scan_text();
        t_match r;
        int     n;
        int     k;
        r = '0;
        r.overflow = ovf_any;
        if (pat_len == 0) begin
            r.found = 1'b1;
            return r;
        end
        if (txt_len < pat_len) return r;
        n = pat_len - 1;
        while (n < txt_len) begin
            k = 0;
            while (k < pat_len && pat_mem[pat_len - 1 - k] == txt_mem[n - k]) k++;
            if (k == pat_len) begin
                r.found    = 1'b1;
                r.position = POS_W'(n + 1 - pat_len);
                return r;
            end
            n += skip_ok[txt_mem[n]] ? int'(skip_dist[txt_mem[n]]) : pat_len;
        end
        return r;
    endfunction

    // Advance the predictor by one accepted transaction; queue a result on a text close.
    function automatic void predict_search(logic op, logic [7:0] b, logic lst);
        if (op == OP_PATTERN) begin
            if (pat_done) begin
                pat_len  = 0;
                txt_len  = 0;
                txt_done = 1'b1;
                pat_ovf  = 1'b0;
                ovf_any  = 1'b0;
                for (int c = 0; c < 256; c++) skip_ok[c] = 1'b0;
                pat_done = 1'b0;
            end
            if (pat_len < PMAX) begin
                pat_mem[pat_len] = b;
                pat_len++;
            end else begin
                pat_ovf = 1'b1;
                ovf_any = 1'b1;
            end
            if (lst) close_pattern();
        end else begin
            // A text byte closes any open pattern first.
            if (!pat_done) close_pattern();
            if (txt_done) begin
                txt_len  = 0;
                ovf_any  = pat_ovf;
                txt_done = 1'b0;
            end
            if (txt_len < TMAX) begin
                txt_mem[txt_len] = b;
                txt_len++;
            end else begin
                ovf_any = 1'b1;
            end
            if (lst) begin
                txt_done = 1'b1;
                pending_matches.push_back(scan_text());
            end
        end
    endfunction

    // Drive one transaction and hold it until the block accepts it.
    task automatic send_byte(logic op, logic [7:0] b, logic lst);
        while (!quiet_mode && $urandom_range(99) < 21) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_op        <= op;
        i_data_byte <= b;
        i_last      <= lst;
        do @(posedge i_clk); while (o_stall);
        predict_search(op, b, lst);
    endtask

    task automatic send_string(logic op, logic [7:0] s [$]);
        foreach (s[i]) send_byte(op, s[i], i == s.size() - 1);
    endtask

    // Result side: random stall, compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (pending_matches.size() == 0) begin
                    $error("unexpected result: found=%0d position=%0d overflow=%0d",
                           o_found, o_position, o_overflow);
                    errors++;
                end else begin
                    t_match e;
                    e = pending_matches.pop_front();
                    if (o_found !== e.found) begin
                        $error("found: expected %0d, actual %0d", e.found, o_found);
                        errors++;
                    end
                    if (o_position !== e.position) begin
                        $error("position: expected %0d, actual %0d", e.position, o_position);
                        errors++;
                    end
                    if (o_overflow !== e.overflow) begin
                        $error("overflow: expected %0d, actual %0d", e.overflow, o_overflow);
                        errors++;
                    end
                    results_seen++;
                    found_seen += e.found;
                    ovf_seen   += e.overflow;
                end
            end
            i_stall <= !quiet_mode && ($urandom_range(99) < 21);
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Directed rows: a text byte with last set closes the text and produces a result.
    function automatic t_row mk(logic op, logic [7:0] b, logic lst, logic ht = 1'b0,
                                logic f = 1'b0, int p = 0, logic ov = 1'b0);
        t_row r;
        r.op        = op;
        r.data_byte = b;
        r.last      = lst;
        r.has_typed = ht;
        r.typed     = '{f, POS_W'(p), ov};
        return r;
    endfunction

    initial begin
        t_row        rows [$];
        logic [7:0]  pat [$];
        logic [7:0]  txt [$];
        int          n_items;
        int          plen;
        int          tlen;
        int          at;
        int          kind;
        t_match      chk;

        errors       = 0;
        results_seen = 0;
        found_seen   = 0;
        ovf_seen     = 0;
        cycles       = 0;
        quiet_mode   = 1'b0;
        i_valid      = 1'b0;
        i_op         = OP_PATTERN;
        i_data_byte  = 8'h00;
        i_last       = 1'b0;
        i_stall      = 1'b0;
        i_rst_n      = 1'b0;
        pat_len  = 0;
        txt_len  = 0;
        ovf_any  = 1'b0;
        pat_done = 1'b1;
        txt_done = 1'b1;
        pat_ovf  = 1'b0;
        for (int c = 0; c < 256; c++) skip_ok[c] = 1'b0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty pattern after reset matches at zero, even for a one-byte text.
        rows.push_back(mk(OP_TEXT, 8'hFF, 1'b1, 1'b1, 1'b1, 0, 1'b0));
        // Pattern "00 FF", text "FF 00 FF": match at 1.
        rows.push_back(mk(OP_PATTERN, 8'h00, 1'b0));
        rows.push_back(mk(OP_PATTERN, 8'hFF, 1'b1));
        rows.push_back(mk(OP_TEXT, 8'hFF, 1'b0));
        rows.push_back(mk(OP_TEXT, 8'h00, 1'b0));
        rows.push_back(mk(OP_TEXT, 8'hFF, 1'b1, 1'b1, 1'b1, 1, 1'b0));
        // New text with the same pattern, shorter than the pattern: not found.
        rows.push_back(mk(OP_TEXT, 8'h00, 1'b1, 1'b1, 1'b0, 0, 1'b0));
        // Pattern left open; text closes it first. Pattern "A5 5A".
        rows.push_back(mk(OP_PATTERN, 8'hA5, 1'b0));
        rows.push_back(mk(OP_PATTERN, 8'h5A, 1'b0));
        rows.push_back(mk(OP_TEXT, 8'h5A, 1'b0));
        rows.push_back(mk(OP_TEXT, 8'hA5, 1'b0));
        rows.push_back(mk(OP_TEXT, 8'h5A, 1'b1, 1'b1, 1'b1, 1, 1'b0));
        // Repeated byte pattern "AA AA AA" against a text with a mismatch inside.
        rows.push_back(mk(OP_PATTERN, 8'hAA, 1'b0));
        rows.push_back(mk(OP_PATTERN, 8'hAA, 1'b0));
        rows.push_back(mk(OP_PATTERN, 8'hAA, 1'b1));
        rows.push_back(mk(OP_TEXT, 8'hAA, 1'b0));
        rows.push_back(mk(OP_TEXT, 8'h55, 1'b0));
        rows.push_back(mk(OP_TEXT, 8'hAA, 1'b0));
        rows.push_back(mk(OP_TEXT, 8'hAA, 1'b0));
        rows.push_back(mk(OP_TEXT, 8'hAA, 1'b1, 1'b1, 1'b1, 2, 1'b0));
        foreach (rows[i]) begin
            send_byte(rows[i].op, rows[i].data_byte, rows[i].last);
            if (rows[i].has_typed) begin
                chk = pending_matches[pending_matches.size() - 1];
                if (chk !== rows[i].typed) begin
                    $error("directed row %0d: typed %h, predicted %h", i, rows[i].typed, chk);
                    errors++;
                end
            end
        end

        // Pattern overflow: 66 bytes, the tail dropped; the last dropped byte closes it.
        pat.delete();
        for (int i = 0; i < PMAX + 2; i++) pat.push_back(8'($urandom_range(1)));
        send_string(OP_PATTERN, pat);
        txt.delete();
        for (int i = 0; i < 200; i++) txt.push_back(8'($urandom_range(1)));
        send_string(OP_TEXT, txt);

        // Random part: mostly pattern then text with planted matches, some noise.
        n_items = 0;
        while (n_items < 1100 || results_seen + pending_matches.size() < 60) begin
            // A long quiet stretch with no idling on either side.
            quiet_mode = (n_items > 600 && n_items < 800);
            kind = $urandom_range(9);
            if (kind < 8) begin
                plen = ($urandom_range(9) == 0) ? $urandom_range(PMAX + 3, 20)
                                                : $urandom_range(6, 1);
                pat.delete();
                for (int i = 0; i < plen; i++)
                    pat.push_back($urandom_range(1) ? 8'($urandom_range(3) + 8'h61)
                                                    : 8'($urandom()));
                if (kind != 0) send_string(OP_PATTERN, pat);
                for (int t = 0; t < $urandom_range(3, 1); t++) begin
                    tlen = $urandom_range(40, 1);
                    txt.delete();
                    for (int i = 0; i < tlen; i++)
                        txt.push_back($urandom_range(3) != 0 ? 8'($urandom_range(3) + 8'h61)
                                                             : 8'($urandom()));
                    // Plant the pattern somewhere in most texts.
                    if ($urandom_range(2) != 0 && plen <= tlen) begin
                        at = $urandom_range(tlen - plen);
                        for (int i = 0; i < plen; i++) txt[at + i] = pat[i];
                    end
                    send_string(OP_TEXT, txt);
                    n_items += tlen;
                end
                n_items += plen;
            end else begin
                // Noise: lone bytes with random op and last.
                for (int i = 0; i < 5; i++) begin
                    send_byte(logic'($urandom_range(1)), 8'($urandom()),
                              logic'($urandom_range(1)));
                    n_items++;
                end
            end
        end
        quiet_mode = 1'b0;
        i_valid <= 1'b0;

        // Drain, then give the search engine time to finish anything in flight.
        while (pending_matches.size() != 0) @(posedge i_clk);
        repeat (500) @(posedge i_clk);

        $display("Checked %0d search results (%0d found, %0d with overflow) over %0d cycles.",
                 results_seen, found_seen, ovf_seen, cycles);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

/* files.f */
design/hss_pkg.sv
design/hss_front.sv
design/hss_queue.sv
design/hss_back.sv
design/horspool_substring_search.sv
tb/testbench.sv
